FILE: rtl/core/grmwc_pkg.sv
package grmwc_pkg;

  localparam int MAP_W      = 16;
  localparam int MAP_H      = 16;
  localparam int MAP_DEPTH  = MAP_W * MAP_H;
  localparam int MAP_AW     = $clog2(MAP_DEPTH);
  localparam logic [11:0] MAX_STEPS = 12'd4095;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_ANGLE  = 3'd5;

  localparam logic FUNC_MAP_WRITE = 1'b0;
  localparam logic FUNC_CAST_RAY  = 1'b1;

  localparam int DIV_N_W   = 24;
  localparam int DIV_D_W   = 20;
  localparam int DIV_CNT_W = 5;
  localparam int REM_W     = 22;

  // quarter-wave sine, round(256*sin(k*pi/32))
  function automatic logic [8:0] qsine(input logic [4:0] k);
    logic [8:0] v;
    unique case (k)
      5'd0:    v = 9'd0;
      5'd1:    v = 9'd25;
      5'd2:    v = 9'd50;
      5'd3:    v = 9'd74;
      5'd4:    v = 9'd98;
      5'd5:    v = 9'd121;
      5'd6:    v = 9'd142;
      5'd7:    v = 9'd162;
      5'd8:    v = 9'd181;
      5'd9:    v = 9'd198;
      5'd10:   v = 9'd213;
      5'd11:   v = 9'd226;
      5'd12:   v = 9'd237;
      5'd13:   v = 9'd245;
      5'd14:   v = 9'd251;
      5'd15:   v = 9'd255;
      default: v = 9'd256;
    endcase
    return v;
  endfunction

  function automatic logic signed [9:0] sine_q8(input logic [9:0] a);
    logic [8:0]  x;
    logic [4:0]  i;
    logic [3:0]  f;
    logic [8:0]  t0;
    logic [8:0]  t1;
    logic [12:0] p;
    logic [9:0]  v;
    x = a[8] ? (9'd256 - {1'b0, a[7:0]}) : {1'b0, a[7:0]};
    i = x[8:4];
    f = x[3:0];
    t0 = qsine(i);
    t1 = qsine(i + 5'd1);
    p = {4'd0, t1 - t0} * {9'd0, f};
    if (i[4]) begin
      v = 10'd256;
    end else begin
      v = {1'b0, t0} + {1'b0, p[12:4]};
    end
    return a[9] ? -$signed(v) : $signed(v);
  endfunction

  function automatic logic [23:0] wall_color(input logic [3:0] code);
    logic [23:0] c;
    unique case (code)
      4'd1:    c = 24'hffffff;
      4'd2:    c = 24'h00ff00;
      4'd3:    c = 24'h0000ff;
      4'd4:    c = 24'hffff00;
      4'd5:    c = 24'hff00ff;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/grmwc_if.sv
interface grmwc_in_if;
  logic              valid;
  logic              ready;
  logic              func;
  logic signed [9:0] column;
  logic [3:0]        cell_row;
  logic [3:0]        cell_col;
  logic [3:0]        cell_value;

  modport source(output valid, func, column, cell_row, cell_col, cell_value, input ready);
  modport sink(input valid, func, column, cell_row, cell_col, cell_value, output ready);
endinterface

interface grmwc_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] rect_x;
  logic [11:0] rect_y;
  logic [11:0] slice_width;
  logic [11:0] wall_height;
  logic [3:0]  hit_code;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [11:0] step_count;

  modport source(output valid, rect_x, rect_y, slice_width, wall_height, hit_code, red, green,
                 blue, step_count, input ready);
  modport sink(input valid, rect_x, rect_y, slice_width, wall_height, hit_code, red, green,
               blue, step_count, output ready);
endinterface

FILE: rtl/core/grid_ray_march_wall_column_core.sv
// map write: written into the map when accepted, no result
// ray request: five passes of the shared restoring divider (four when the ray starts
// in a wall or off the map) plus, per unit march step, a map read, a hit test and
// cell adjusts while an index still has to move; one ray at a time, the next request
// waits until this one is done
// reset: synchronous; the 256-cell map is then cleared one cell a cycle
module grid_ray_march_wall_column_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [grmwc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [grmwc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  grmwc_in_if.sink                            in_ch,
  grmwc_out_if.source                         out_ch
);

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b00000000001,
    ST_IDLE  = 11'b00000000010,
    ST_DOFF  = 11'b00000000100,
    ST_DCX   = 11'b00000001000,
    ST_DCY   = 11'b00000010000,
    ST_RD    = 11'b00000100000,
    ST_TEST  = 11'b00001000000,
    ST_ADJ   = 11'b00010000000,
    ST_DHT   = 11'b00100000000,
    ST_DWD   = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } state_t;

  state_t state;

  logic [11:0] disp_width;
  logic [11:0] disp_height;
  logic [10:0] line_count;
  logic [19:0] player_x;
  logic [19:0] player_y;
  logic [9:0]  player_angle;

  logic [3:0]  map_mem [grmwc_pkg::MAP_DEPTH];
  logic [3:0]  mem_q;
  logic [grmwc_pkg::MAP_AW:0] clr_idx;

  logic signed [9:0]  col_q;
  logic [9:0]         angle;
  logic signed [5:0]  cx;
  logic signed [5:0]  cy;
  logic signed [grmwc_pkg::REM_W-1:0] remx;
  logic signed [grmwc_pkg::REM_W-1:0] remy;
  logic [11:0] steps;
  logic [3:0]  code;
  logic [11:0] height;
  logic [11:0] wdiv;

  logic [grmwc_pkg::DIV_D_W-1:0]   div_rem;
  logic [grmwc_pkg::DIV_N_W-1:0]   div_quo;
  logic [grmwc_pkg::DIV_D_W-1:0]   div_d;
  logic [grmwc_pkg::DIV_CNT_W-1:0] div_cnt;

  logic [11:0] w_eff;
  logic [11:0] h_eff;
  logic [10:0] lc_eff;
  logic [grmwc_pkg::DIV_D_W-1:0] x_den;
  logic [grmwc_pkg::DIV_D_W-1:0] y_den;
  logic signed [grmwc_pkg::REM_W-1:0] x_den_s;
  logic signed [grmwc_pkg::REM_W-1:0] y_den_s;
  logic signed [9:0] sin_x;
  logic signed [9:0] sin_y;
  logic signed [9:0] dy;
  logic signed [grmwc_pkg::REM_W-1:0] step_x;
  logic signed [grmwc_pkg::REM_W-1:0] step_y;
  logic [9:0]  in_abs;
  logic [9:0]  offset;
  logic [20:0] ht_num;
  logic [grmwc_pkg::DIV_D_W:0] trial;
  logic        trial_ge;
  logic        div_done;
  logic        x_in;
  logic        y_in;
  logic        x_done;
  logic        y_done;
  logic        in_acc;
  logic [11:0] rx_t;
  logic [11:0] rx;
  logic [23:0] color;

  assign w_eff  = (disp_width == 12'd0) ? 12'd1 : disp_width;
  assign h_eff  = (disp_height == 12'd0) ? 12'd1 : disp_height;
  assign lc_eff = (line_count == 11'd0) ? 11'd1 : line_count;
  assign x_den  = {w_eff, 8'd0};
  assign y_den  = {h_eff, 8'd0};
  assign x_den_s = $signed({2'b00, x_den});
  assign y_den_s = $signed({2'b00, y_den});

  assign sin_x  = grmwc_pkg::sine_q8(angle + 10'd256);
  assign sin_y  = grmwc_pkg::sine_q8(angle);
  assign dy     = -sin_y;
  assign step_x = {{8{sin_x[9]}}, sin_x, 4'd0};
  assign step_y = {{8{dy[9]}}, dy, 4'd0};

  assign in_abs = in_ch.column[9] ? (~in_ch.column + 10'd1) : in_ch.column;
  assign offset = col_q[9] ? (~div_quo[9:0] + 10'd1) : div_quo[9:0];
  assign ht_num = {8'd0, disp_height, 1'b0} * {13'd0, disp_height[11:4]};

  assign trial    = {div_rem, div_quo[grmwc_pkg::DIV_N_W-1]};
  assign trial_ge = (trial >= {1'b0, div_d});
  assign div_done = (div_cnt == '0);

  assign x_in   = (cx[5:4] == 2'b00);
  assign y_in   = (cy[5:4] == 2'b00);
  assign x_done = !x_in || (!remx[grmwc_pkg::REM_W-1] && (remx < x_den_s));
  assign y_done = !y_in || (!remy[grmwc_pkg::REM_W-1] && (remy < y_den_s));

  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign rx_t  = {1'b0, line_count} - {{2{col_q[9]}}, col_q} - {2'b00, line_count[10:1]};
  assign rx    = rx_t * wdiv;
  assign color = grmwc_pkg::wall_color(code);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      disp_width   <= 12'd640;
      disp_height  <= 12'd480;
      line_count   <= 11'd128;
      player_x     <= 20'd0;
      player_y     <= 20'd0;
      player_angle <= 10'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        grmwc_pkg::CFG_SCREEN_WIDTH:  disp_width   <= cfg_wdata[11:0];
        grmwc_pkg::CFG_SCREEN_HEIGHT: disp_height  <= cfg_wdata[11:0];
        grmwc_pkg::CFG_LINE_COUNT:    line_count   <= cfg_wdata[10:0];
        grmwc_pkg::CFG_PLAYER_X:      player_x     <= cfg_wdata;
        grmwc_pkg::CFG_PLAYER_Y:      player_y     <= cfg_wdata;
        grmwc_pkg::CFG_PLAYER_ANGLE:  player_angle <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // map memory
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      map_mem[clr_idx[grmwc_pkg::MAP_AW-1:0]] <= 4'd0;
    end else if (in_acc && (in_ch.func == grmwc_pkg::FUNC_MAP_WRITE)) begin
      map_mem[{in_ch.cell_row, in_ch.cell_col}] <= in_ch.cell_value;
    end
    if (state == ST_RD) begin
      mem_q <= map_mem[{cy[3:0], cx[3:0]}];
    end
  end

  // sequencer, shared divider and march datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_idx      <= '0;
      div_cnt      <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && (state != ST_OUT)) begin
        out_ch.valid <= 1'b0;
      end
      if (!div_done) begin
        div_rem <= trial_ge ? (trial[grmwc_pkg::DIV_D_W-1:0] - div_d)
                            : trial[grmwc_pkg::DIV_D_W-1:0];
        div_quo <= {div_quo[grmwc_pkg::DIV_N_W-2:0], trial_ge};
        div_cnt <= div_cnt - 1'b1;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == (grmwc_pkg::MAP_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc && (in_ch.func == grmwc_pkg::FUNC_CAST_RAY)) begin
            col_q   <= in_ch.column;
            div_rem <= '0;
            div_quo <= {6'd0, in_abs, 8'd0};
            div_d   <= {9'd0, lc_eff};
            div_cnt <= grmwc_pkg::DIV_CNT_W'(grmwc_pkg::DIV_N_W);
            state   <= ST_DOFF;
          end
        end
        ST_DOFF: begin
          if (div_done) begin
            angle   <= player_angle + offset;
            div_rem <= '0;
            div_quo <= {player_x, 4'd0};
            div_d   <= x_den;
            div_cnt <= grmwc_pkg::DIV_CNT_W'(grmwc_pkg::DIV_N_W);
            state   <= ST_DCX;
          end
        end
        ST_DCX: begin
          if (div_done) begin
            cx      <= (div_quo >= 24'd16) ? 6'sd16 : $signed({2'b00, div_quo[3:0]});
            remx    <= $signed({2'b00, div_rem});
            div_rem <= '0;
            div_quo <= {player_y, 4'd0};
            div_d   <= y_den;
            div_cnt <= grmwc_pkg::DIV_CNT_W'(grmwc_pkg::DIV_N_W);
            state   <= ST_DCY;
          end
        end
        ST_DCY: begin
          if (div_done) begin
            cy    <= (div_quo >= 24'd16) ? 6'sd16 : $signed({2'b00, div_quo[3:0]});
            remy  <= $signed({2'b00, div_rem});
            steps <= 12'd0;
            state <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_TEST;
        end
        ST_TEST: begin
          if (!x_in || !y_in || (mem_q != 4'd0) || (steps == grmwc_pkg::MAX_STEPS)) begin
            code <= (x_in && y_in) ? mem_q : 4'd0;
            if (steps == 12'd0) begin
              height  <= disp_height;
              div_rem <= '0;
              div_quo <= {12'd0, disp_width};
              div_d   <= {9'd0, lc_eff};
              div_cnt <= grmwc_pkg::DIV_CNT_W'(grmwc_pkg::DIV_N_W);
              state   <= ST_DWD;
            end else begin
              div_rem <= '0;
              div_quo <= {3'd0, ht_num};
              div_d   <= {8'd0, steps};
              div_cnt <= grmwc_pkg::DIV_CNT_W'(grmwc_pkg::DIV_N_W);
              state   <= ST_DHT;
            end
          end else begin
            remx  <= remx + step_x;
            remy  <= remy + step_y;
            steps <= steps + 12'd1;
            state <= ST_ADJ;
          end
        end
        ST_ADJ: begin
          // walk the cell index one cell a cycle until the remainder is back in range
          if (x_in && remx[grmwc_pkg::REM_W-1]) begin
            cx   <= cx - 6'sd1;
            remx <= remx + x_den_s;
          end else if (!x_done) begin
            cx   <= cx + 6'sd1;
            remx <= remx - x_den_s;
          end
          if (y_in && remy[grmwc_pkg::REM_W-1]) begin
            cy   <= cy - 6'sd1;
            remy <= remy + y_den_s;
          end else if (!y_done) begin
            cy   <= cy + 6'sd1;
            remy <= remy - y_den_s;
          end
          if (x_done && y_done) begin
            state <= ST_RD;
          end
        end
        ST_DHT: begin
          if (div_done) begin
            height  <= (div_quo > {12'd0, disp_height}) ? disp_height : div_quo[11:0];
            div_rem <= '0;
            div_quo <= {12'd0, disp_width};
            div_d   <= {9'd0, lc_eff};
            div_cnt <= grmwc_pkg::DIV_CNT_W'(grmwc_pkg::DIV_N_W);
            state   <= ST_DWD;
          end
        end
        ST_DWD: begin
          if (div_done) begin
            wdiv  <= div_quo[11:0];
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid       <= 1'b1;
            out_ch.rect_x      <= rx;
            out_ch.rect_y      <= 12'((disp_height - height) >> 1);
            out_ch.slice_width <= wdiv;
            out_ch.wall_height <= height;
            out_ch.hit_code    <= code;
            out_ch.red         <= color[23:16];
            out_ch.green       <= color[15:8];
            out_ch.blue        <= color[7:0];
            out_ch.step_count  <= steps;
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_height_clamped: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.wall_height <= disp_height))
    else $error("wall height above screen height");

  a_slice_fits: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (({1'b0, out_ch.rect_y, 1'b0} + {2'b00, out_ch.wall_height})
                      <= {2'b00, disp_height}))
    else $error("slice does not fit the screen");

  a_adj_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADJ) |=> ((state == ST_ADJ) || (state == ST_RD)))
    else $error("cell adjust left to a wrong state");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DCX) || (state == ST_DCY) || (state == ST_DHT) || (state == ST_DWD))
    |-> (div_rem < div_d))
    else $error("divider remainder not below divisor");

  a_cell_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TEST) |-> ((cx >= -6'sd1) && (cx <= 6'sd16) && (cy >= -6'sd1) && (cy <= 6'sd16)))
    else $error("cell index ran past the map border");
`endif

endmodule

FILE: sim/tb_grid_ray_march_wall_column_core.sv
`timescale 1ns / 1ps

module tb_grid_ray_march_wall_column_core;

  localparam int CYCLE_LIMIT = 60000000;

  typedef struct {
    logic              func;
    logic signed [9:0] column;
    logic [3:0]        cell_row;
    logic [3:0]        cell_col;
    logic [3:0]        cell_value;
  } request_t;

  typedef struct {
    logic [11:0] rect_x;
    logic [11:0] rect_y;
    logic [11:0] slice_width;
    logic [11:0] wall_height;
    logic [3:0]  hit_code;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] step_count;
  } slice_t;

  class slice_scoreboard;
    slice_t      slices_due[$];
    int          errors;
    bit [3:0]    grid[grmwc_pkg::MAP_DEPTH];
    int unsigned scr_w, scr_h, line_cnt, pos_x, pos_y, heading;
    int          qtab[17];

    function new();
      qtab = '{0, 25, 50, 74, 98, 121, 142, 162, 181, 198, 213, 226, 237, 245, 251, 255, 256};
      errors = 0;
      foreach (grid[i]) grid[i] = 0;
      scr_w = 640;
      scr_h = 480;
      line_cnt = 128;
      pos_x = 0;
      pos_y = 0;
      heading = 0;
    endfunction

    function void set_reg(logic [grmwc_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
      case (idx)
        grmwc_pkg::CFG_SCREEN_WIDTH:  scr_w = val & 12'hfff;
        grmwc_pkg::CFG_SCREEN_HEIGHT: scr_h = val & 12'hfff;
        grmwc_pkg::CFG_LINE_COUNT:    line_cnt = val & 11'h7ff;
        grmwc_pkg::CFG_PLAYER_X:      pos_x = val & 20'hfffff;
        grmwc_pkg::CFG_PLAYER_Y:      pos_y = val & 20'hfffff;
        grmwc_pkg::CFG_PLAYER_ANGLE:  heading = val & 10'h3ff;
        default: ;
      endcase
    endfunction

    function int sine(int unsigned a);
      int unsigned r, q, x, i, f;
      int v;
      a &= 1023;
      r = a & 255;
      q = a >> 8;
      x = (q & 1) ? 256 - r : r;
      i = x >> 4;
      f = x & 15;
      if (i >= 16) v = 256;
      else v = qtab[i] + (((qtab[i+1] - qtab[i]) * f) >> 4);
      return (q & 2) ? -v : v;
    endfunction

    function bit [3:0] cell_code(longint px, longint py, output bit on_map);
      longint w, h, cx, cy;
      w = (scr_w != 0) ? scr_w : 1;
      h = (scr_h != 0) ? scr_h : 1;
      on_map = 0;
      if (px < 0 || py < 0) return 0;
      cx = (px * grmwc_pkg::MAP_W) / (w * 256);
      cy = (py * grmwc_pkg::MAP_H) / (h * 256);
      if (cx >= grmwc_pkg::MAP_W || cy >= grmwc_pkg::MAP_H) return 0;
      on_map = 1;
      return grid[cy * grmwc_pkg::MAP_W + cx];
    endfunction

    function void note_request(request_t r);
      int col, lc, ofs, dx, dy, rx;
      int unsigned ang, steps, ht, wdiv;
      longint px, py;
      bit on_map;
      bit [3:0] code;
      slice_t s;
      if (r.func == grmwc_pkg::FUNC_MAP_WRITE) begin
        grid[r.cell_row * grmwc_pkg::MAP_W + r.cell_col] = r.cell_value;
        return;
      end
      col = r.column;
      lc = (line_cnt != 0) ? line_cnt : 1;
      ofs = (256 * col) / lc;
      ang = (heading + ofs) & 1023;
      dx = sine(ang + 256);
      dy = -sine(ang);
      px = pos_x;
      py = pos_y;
      steps = 0;
      while (steps < grmwc_pkg::MAX_STEPS) begin
        code = cell_code(px, py, on_map);
        if (!on_map || code != 0) break;
        px += dx;
        py += dy;
        steps++;
      end
      code = cell_code(px, py, on_map);
      if (steps == 0) ht = scr_h;
      else begin
        ht = (2 * scr_h * (scr_h / 16)) / steps;
        if (ht > scr_h) ht = scr_h;
      end
      wdiv = scr_w / lc;
      rx = (int'(line_cnt) - (col + int'(line_cnt) / 2)) * int'(wdiv);
      s.rect_x = rx[11:0];
      s.rect_y = 12'((scr_h - ht) / 2);
      s.slice_width = 12'(wdiv);
      s.wall_height = 12'(ht);
      s.hit_code = code;
      {s.red, s.green, s.blue} = 24'h000000;
      case (code)
        4'd1: {s.red, s.green, s.blue} = 24'hffffff;
        4'd2: {s.red, s.green, s.blue} = 24'h00ff00;
        4'd3: {s.red, s.green, s.blue} = 24'h0000ff;
        4'd4: {s.red, s.green, s.blue} = 24'hffff00;
        4'd5: {s.red, s.green, s.blue} = 24'hff00ff;
        default: ;
      endcase
      s.step_count = 12'(steps);
      slices_due.push_back(s);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_slice(slice_t got);
      slice_t e;
      if (slices_due.size() == 0) begin
        report("slice with no request pending");
        return;
      end
      e = slices_due.pop_front();
      if (got.rect_x !== e.rect_x) report($sformatf("rect_x %0d exp %0d", got.rect_x, e.rect_x));
      if (got.rect_y !== e.rect_y) report($sformatf("rect_y %0d exp %0d", got.rect_y, e.rect_y));
      if (got.slice_width !== e.slice_width)
        report($sformatf("slice_width %0d exp %0d", got.slice_width, e.slice_width));
      if (got.wall_height !== e.wall_height)
        report($sformatf("wall_height %0d exp %0d", got.wall_height, e.wall_height));
      if (got.hit_code !== e.hit_code)
        report($sformatf("hit_code %0d exp %0d", got.hit_code, e.hit_code));
      if ({got.red, got.green, got.blue} !== {e.red, e.green, e.blue})
        report($sformatf("color %h%h%h exp %h%h%h", got.red, got.green, got.blue,
                         e.red, e.green, e.blue));
      if (got.step_count !== e.step_count)
        report($sformatf("step_count %0d exp %0d", got.step_count, e.step_count));
    endtask
  endclass

  logic clk = 0;
  logic rst;
  logic cfg_we;
  logic [grmwc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [grmwc_pkg::CFG_DATA_W-1:0] cfg_wdata;
  grmwc_in_if in_ch();
  grmwc_out_if out_ch();

  slice_scoreboard sb = new();
  bit calm = 0;
  int stall = 0;
  int cycles = 0;

  grid_ray_march_wall_column_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    slice_t got;
    if (rst) begin
      out_ch.ready <= 1'b1;
      stall = 0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready) begin
        got.rect_x = out_ch.rect_x;
        got.rect_y = out_ch.rect_y;
        got.slice_width = out_ch.slice_width;
        got.wall_height = out_ch.wall_height;
        got.hit_code = out_ch.hit_code;
        got.red = out_ch.red;
        got.green = out_ch.green;
        got.blue = out_ch.blue;
        got.step_count = out_ch.step_count;
        sb.check_slice(got);
        stall = calm ? 0 : $urandom_range(0, 19);
        if (stall > 0) out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        if (stall == 0) out_ch.ready <= 1'b1;
      end
    end
  end

  task cfg_write(logic [grmwc_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[grmwc_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    sb.set_reg(idx, val & 20'hfffff);
  endtask

  task setup(int unsigned w, int unsigned h, int unsigned lc, int unsigned x, int unsigned y,
             int unsigned a);
    cfg_write(grmwc_pkg::CFG_SCREEN_WIDTH, w);
    cfg_write(grmwc_pkg::CFG_SCREEN_HEIGHT, h);
    cfg_write(grmwc_pkg::CFG_LINE_COUNT, lc);
    cfg_write(grmwc_pkg::CFG_PLAYER_X, x);
    cfg_write(grmwc_pkg::CFG_PLAYER_Y, y);
    cfg_write(grmwc_pkg::CFG_PLAYER_ANGLE, a);
    cfg_we <= 1'b0;
  endtask

  task send(request_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= r.func;
    in_ch.column <= r.column;
    in_ch.cell_row <= r.cell_row;
    in_ch.cell_col <= r.cell_col;
    in_ch.cell_value <= r.cell_value;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(r);
  endtask

  task cast(int col);
    request_t r;
    r.func = grmwc_pkg::FUNC_CAST_RAY;
    r.column = 10'(col);
    r.cell_row = 4'($urandom);
    r.cell_col = 4'($urandom);
    r.cell_value = 4'($urandom);
    send(r);
  endtask

  task put_cell(int row, int col, int val);
    request_t r;
    r.func = grmwc_pkg::FUNC_MAP_WRITE;
    r.column = 10'($urandom);
    r.cell_row = 4'(row);
    r.cell_col = 4'(col);
    r.cell_value = 4'(val);
    send(r);
  endtask

  task drain();
    in_ch.valid <= 1'b0;
    while (sb.slices_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    int w, h, lc, n, lo, hi, col;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.func <= grmwc_pkg::FUNC_MAP_WRITE;
    in_ch.column <= '0;
    in_ch.cell_row <= '0;
    in_ch.cell_col <= '0;
    in_ch.cell_value <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty map, long marches up to the step limit
    setup(4095, 4095, 2, 0, 0, 896);
    cast(0);
    cast(-1);
    drain();
    setup(640, 480, 128, 0, 0, 0);
    cast(0);
    cast(-64);
    cast(63);
    cast(-512);
    cast(511);
    put_cell(0, 0, 1);
    cast(0);
    put_cell(0, 1, 2);
    put_cell(1, 0, 3);
    put_cell(15, 15, 15);
    put_cell(0, 0, 0);
    drain();
    setup(64, 64, 1024, 60 * 256, 60 * 256, 128);
    cast(-512);
    cast(511);
    put_cell(15, 14, 4);
    put_cell(14, 15, 5);
    cast(0);
    drain();
    setup(0, 0, 0, 10, 10, 512);
    cast(0);
    cast(-3);
    drain();
    setup(1, 16, 2047, 20'hfffff, 20'hfffff, 1023);
    cfg_write(3'd6, 20'h12345);
    cfg_write(3'd7, 20'hfffff);
    cfg_we <= 1'b0;
    cast(5);
    drain();

    for (int ph = 0; ph < 13; ph++) begin
      calm = (ph % 4 == 3);
      case ($urandom_range(0, 9))
        0: begin w = 4095; h = 4095; end
        1: begin w = $urandom_range(0, 3); h = $urandom_range(0, 20); end
        default: begin w = $urandom_range(16, 200); h = $urandom_range(16, 200); end
      endcase
      lc = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2047) : $urandom_range(2, 1024);
      if ($urandom_range(0, 4) == 0)
        setup(w, h, lc, $urandom_range(0, 20'hfffff), $urandom_range(0, 20'hfffff),
              $urandom_range(0, 1023));
      else
        setup(w, h, lc, $urandom_range(0, (w > 0 ? w : 1) * 256 - 1),
              $urandom_range(0, (h > 0 ? h : 1) * 256 - 1), $urandom_range(0, 1023));
      n = (w + h > 1000) ? 12 : 70;
      if (w + h > 1000)
        for (int k = 0; k < 40; k++)
          put_cell($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(1, 15));
      lc = (lc & 2047) < 2 ? 2 : (lc & 2047);
      lo = -(lc / 2);
      hi = lc / 2 - 1;
      if (lo < -512) lo = -512;
      if (hi > 511) hi = 511;
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 3) == 0)
          put_cell($urandom_range(0, 15), $urandom_range(0, 15),
                   ($urandom_range(0, 9) < 5) ? 0 : $urandom_range(1, 15));
        else begin
          if ($urandom_range(0, 6) == 0) col = $signed(10'($urandom));
          else col = lo + int'($urandom_range(0, hi - lo));
          cast(col);
        end
      end
      drain();
    end

    drain();
    if (sb.slices_due.size() != 0) sb.report("slices still pending at end");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: grid_ray_march_wall_column_core.f
rtl/core/grmwc_pkg.sv
rtl/core/grmwc_if.sv
rtl/core/grid_ray_march_wall_column_core.sv
sim/tb_grid_ray_march_wall_column_core.sv
